@@ rtl/core/lpwa_pkg.sv @@
package lpwa_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SNAP_W      = 8;
  localparam int WEIGHT_W    = 16;
  localparam int POS_W       = 11;
  localparam int COUNT_W     = 4;
  localparam int LOST_W      = 8;
  localparam int IDX_W       = 3;
  localparam int SUM_W       = 20;
  localparam int MAG_W       = 19;
  localparam int LIM_W       = 10;
  localparam int REM_W       = 4;
  localparam int ITER_W      = 5;
  localparam int SCALED_W    = 13;
  localparam int PROD_W      = 25;
  localparam int OUT_DATA_W  = 24;

  localparam int POS_LIMIT      = 1000;
  localparam int LOST_THRESHOLD = 3;
  localparam int LOST_MAX       = 255;
  localparam int LOST_SCALE_DEN = 5;

  // Dividing by five is a multiply by 3277 / 2^14; exact for dividends up to 6000.
  localparam int LOST_SCALE_RECIP = 3277;
  localparam int LOST_SCALE_SHIFT = 14;

  localparam logic [SNAP_W-1:0] SNAP_ALL_WHITE = 8'h00;
  localparam logic [SNAP_W-1:0] SNAP_ALL_BLACK = 8'hFF;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef weight_t [NUM_SENSORS-1:0] weights_t;

  typedef struct packed {
    logic [SNAP_W-1:0]  snap;
    logic [COUNT_W-1:0] count;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } back_state_t;

endpackage

@@ rtl/core/lpwa_front.sv @@
module lpwa_front
  import lpwa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [SNAP_W-1:0] s_axis_tdata,
  output logic              item_valid,
  input  logic              item_ready,
  output item_t             item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               push;
  logic               pop;
  item_t              in_item;

  always_comb begin
    in_item.snap  = s_axis_tdata;
    in_item.count = '0;
    for (int i = 0; i < SNAP_W; i++) begin
      in_item.count = in_item.count + COUNT_W'(s_axis_tdata[i]);
    end
  end

  assign s_axis_tready = (fill != CNT_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (fill != '0);
  assign pop           = item_valid && item_ready;
  assign item          = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/lpwa_back.sv @@
module lpwa_back
  import lpwa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  weights_t              weights,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  back_state_t               state;
  back_state_t               state_next;
  logic [SNAP_W-1:0]         snap;
  logic [COUNT_W-1:0]        count;
  logic [IDX_W-1:0]          bit_idx;
  logic signed [SUM_W-1:0]   sum;
  logic [MAG_W-1:0]          dvd;
  logic [REM_W-1:0]          rem;
  logic [COUNT_W-1:0]        dsr;
  logic                      neg;
  logic [ITER_W-1:0]         iter;
  logic [LOST_W-1:0]         lost_run;
  logic [LOST_W-1:0]         lost_run_next;
  logic signed [POS_W-1:0]   last_position;
  logic signed [POS_W-1:0]   pos;
  logic [LIM_W-1:0]          pos_mag;
  logic [LIM_W-1:0]          last_mag;
  logic [SCALED_W-1:0]       last_scaled;
  logic [PROD_W-1:0]         lost_prod;
  logic [REM_W-1:0]          rem_sh;
  logic                      rem_ge;
  logic signed [SUM_W-1:0]   weight_ext;
  logic                      out_free;
  logic                      finish;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          state_next = (item.count == '0) ? ST_FINISH : ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (bit_idx == IDX_W'(NUM_SENSORS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (iter == ITER_W'(MAG_W - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign weight_ext = {{(SUM_W - WEIGHT_W){weights[bit_idx][WEIGHT_W-1]}}, weights[bit_idx]};
  assign last_mag   = last_position[POS_W-1] ? LIM_W'(-last_position) : LIM_W'(last_position);
  assign last_scaled = (SCALED_W'(last_mag) << 2) + (SCALED_W'(last_mag) << 1);
  assign lost_prod  = PROD_W'(last_scaled) * PROD_W'(LOST_SCALE_RECIP);
  assign rem_sh     = {rem[REM_W-2:0], dvd[MAG_W-1]};
  assign rem_ge     = (rem_sh >= dsr);

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          snap    <= item.snap;
          count   <= item.count;
          sum     <= '0;
          bit_idx <= '0;
          rem     <= '0;
          iter    <= '0;
          neg     <= last_position[POS_W-1];
          dvd     <= MAG_W'(lost_prod[PROD_W-1:LOST_SCALE_SHIFT]);
        end
      end
      ST_ACCUM: begin
        if (snap[bit_idx]) begin
          sum <= sum + weight_ext;
        end
        bit_idx <= bit_idx + 1'b1;
      end
      ST_LOAD: begin
        neg <= sum[SUM_W-1];
        dsr <= count;
        dvd <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
      end
      ST_DIVIDE: begin
        rem  <= rem_ge ? rem_sh - dsr : rem_sh;
        dvd  <= {dvd[MAG_W-2:0], rem_ge};
        iter <= iter + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign pos_mag = (dvd > MAG_W'(POS_LIMIT)) ? LIM_W'(POS_LIMIT) : dvd[LIM_W-1:0];
  assign pos     = neg ? -POS_W'(pos_mag) : POS_W'(pos_mag);

  always_comb begin
    if (count != '0) begin
      lost_run_next = '0;
    end else if (lost_run == LOST_W'(LOST_MAX)) begin
      lost_run_next = lost_run;
    end else begin
      lost_run_next = lost_run + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_run      <= '0;
      last_position <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (finish) begin
        lost_run      <= lost_run_next;
        m_axis_tvalid <= 1'b1;
        if (count != '0) begin
          last_position <= pos;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= {6'b0,
                       (snap == SNAP_ALL_BLACK),
                       (snap == SNAP_ALL_WHITE),
                       (lost_run_next >= LOST_W'(LOST_THRESHOLD)),
                       count,
                       pos};
    end
  end

endmodule

@@ rtl/core/line_position_weighted_average.sv @@
// Line position estimator for an 8-sensor line follower.
// The input stream carries one sensor snapshot per transaction; bit i of
// s_axis_tdata is set when sensor i sees the line. The output stream
// carries one result per snapshot, in order: the signed position, the
// number of active sensors and the lost, all-white and all-black flags.
// The eight signed sensor weights are written through the cfg_wr_en,
// cfg_index and cfg_data port; the user must write them only while the
// block is idle, as the block itself does not enforce it. A snapshot
// with any sensor set passes the input queue, accumulates the weights one
// sensor at a time, loads the divider, runs the one-bit-per-cycle restoring
// divider and raises m_axis_tvalid with the registered result. A snapshot
// with no sensor set scales the stored position by a constant multiply
// instead. The back end takes a new snapshot only after the last result is registered.
// A small input queue keeps accepting snapshots while a result waits on a
// stalled receiver; when the queue is full, s_axis_tready falls.
// Reset restores the default weights, clears the queue, the stored last
// position and the lost counter, and drops m_axis_tvalid.
module line_position_weighted_average
  import lpwa_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // line_states[7:0]
  input  logic [SNAP_W-1:0]       s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // position[10:0], active_count[14:11], line_lost[15], all_white[16],
  // all_black[17], zero fill[23:18]
  output logic [OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                    cfg_wr_en,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [WEIGHT_W-1:0]     cfg_data
);

  weights_t weights;
  logic     item_valid;
  logic     item_ready;
  item_t    item;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights[0] <= -WEIGHT_W'(1000);
      weights[1] <= -WEIGHT_W'(700);
      weights[2] <= -WEIGHT_W'(400);
      weights[3] <= -WEIGHT_W'(100);
      weights[4] <= WEIGHT_W'(100);
      weights[5] <= WEIGHT_W'(400);
      weights[6] <= WEIGHT_W'(700);
      weights[7] <= WEIGHT_W'(1000);
    end else if (cfg_wr_en) begin
      weights[cfg_index] <= cfg_data;
    end
  end

  lpwa_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  lpwa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .weights       (weights),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
